// ===== rtl/pepc_pkg.sv =====
// Shared types and constants for the per-exporter protocol counters.
`timescale 1ns / 1ps
package pepc_pkg;
    localparam int TABLE_ENTRIES = 16;
    localparam int NUM_CLASSES   = 4;
    localparam int NUM_KINDS     = 3;
    localparam int ENT_W         = 4;
    localparam int CNT_W         = 64;
    localparam int IVL_W         = 12;
    localparam int STEP_W        = 6;

    localparam logic [1:0] CLS_TCP   = 2'd0;
    localparam logic [1:0] CLS_UDP   = 2'd1;
    localparam logic [1:0] CLS_ICMP  = 2'd2;
    localparam logic [1:0] CLS_OTHER = 2'd3;

    localparam logic [1:0] KIND_FLOW = 2'd0;
    localparam logic [1:0] KIND_PKT  = 2'd1;
    localparam logic [1:0] KIND_BYTE = 2'd2;

    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

    localparam logic       OP_UPDATE = 1'b0;
    localparam logic       OP_DUMP   = 1'b1;

    localparam logic       REG_ENABLE   = 1'b0;
    localparam logic       REG_INTERVAL = 1'b1;

    typedef logic [NUM_KINDS-1:0][CNT_W-1:0] cnt_kinds_t;
    typedef cnt_kinds_t [NUM_CLASSES-1:0] cnt_set_t;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic        upd;
        logic        any_hit;
        logic        clr;
        logic [1:0]  cls;
        logic [31:0] id;
        logic [31:0] pkts;
        logic [39:0] bytes;
    } cell_ctrl_t;

    function automatic logic [1:0] class_of(input logic [7:0] proto);
        logic [1:0] c;
        c = CLS_OTHER;
        if (proto == PROTO_TCP) c = CLS_TCP;
        else if (proto == PROTO_UDP) c = CLS_UDP;
        else if (proto == PROTO_ICMP || proto == PROTO_ICMPV6) c = CLS_ICMP;
        return c;
    endfunction
endpackage

// ===== rtl/pepc_cell.sv =====
// One table cell: exporter id, valid bit and the twelve traffic counters.
`timescale 1ns / 1ps
module pepc_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pepc_pkg::cell_ctrl_t  ctrl,
    input  logic                  clr_sel,
    input  logic                  prev_valid,
    output logic                  valid,
    output logic                  hit,
    output logic [31:0]           id,
    output pepc_pkg::cnt_set_t    cnts
);
    logic                 valid_reg;
    logic [31:0]          id_reg;
    pepc_pkg::cnt_set_t   cnt_reg;
    pepc_pkg::cnt_set_t   cnt_next;
    logic                 alloc;
    logic                 bump;

    assign hit   = valid_reg && (id_reg == ctrl.id);
    // First empty cell behind a filled neighbor takes a new exporter.
    assign alloc = ctrl.upd && !ctrl.any_hit && prev_valid && !valid_reg;
    assign bump  = ctrl.upd && (hit || alloc);
    assign valid = valid_reg;
    assign id    = id_reg;
    assign cnts  = cnt_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (bump)
        begin
            cnt_next[ctrl.cls][pepc_pkg::KIND_FLOW] =
                cnt_reg[ctrl.cls][pepc_pkg::KIND_FLOW] + 64'd1;
            cnt_next[ctrl.cls][pepc_pkg::KIND_PKT] =
                cnt_reg[ctrl.cls][pepc_pkg::KIND_PKT] + {32'd0, ctrl.pkts};
            cnt_next[ctrl.cls][pepc_pkg::KIND_BYTE] =
                cnt_reg[ctrl.cls][pepc_pkg::KIND_BYTE] + {24'd0, ctrl.bytes};
        end
        else if (ctrl.clr && clr_sel)
        begin
            cnt_next[ctrl.cls] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (alloc)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (alloc)
        begin
            id_reg <= ctrl.id;
        end
    end
endmodule

// ===== rtl/pepc_div.sv =====
// Restoring divider: one quotient bit per step, 64-bit dividend, 12-bit divisor.
`timescale 1ns / 1ps
module pepc_div (
    input  logic                         clk,
    input  logic                         load,
    input  logic                         step,
    input  logic [pepc_pkg::CNT_W-1:0]   dividend,
    input  logic [pepc_pkg::IVL_W-1:0]   divisor,
    output logic [pepc_pkg::CNT_W-1:0]   quotient
);
    logic [pepc_pkg::CNT_W-1:0] q_reg;
    logic [pepc_pkg::IVL_W-1:0] r_reg;
    logic [pepc_pkg::IVL_W:0]   r_shift;
    logic [pepc_pkg::IVL_W:0]   r_diff;

    assign r_shift  = {r_reg, q_reg[pepc_pkg::CNT_W-1]};
    assign r_diff   = r_shift - {1'b0, divisor};
    assign quotient = q_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= dividend;
            r_reg <= '0;
        end
        else if (step)
        begin
            if (r_shift >= {1'b0, divisor})
            begin
                r_reg <= r_diff[pepc_pkg::IVL_W-1:0];
                q_reg <= {q_reg[pepc_pkg::CNT_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_shift[pepc_pkg::IVL_W-1:0];
                q_reg <= {q_reg[pepc_pkg::CNT_W-2:0], 1'b0};
            end
        end
    end
endmodule

// ===== rtl/per_exporter_protocol_counters.sv =====
// Top level: exporter table of counting cells, dump sequencer and rate dividers.
`timescale 1ns / 1ps
// Usage
//   Command channel: an item is taken on a rising edge with start high and
//   busy low. Opcode 0 is an update: the exporter is looked up in a row of
//   16 cells in the same edge (a new cell is claimed if the exporter is new)
//   and the flow, packet and byte counters of its protocol class advance.
//   Updates keep busy low; a new command may follow in the very next cycle.
//   Updates are dropped while counting is disabled, and dropped with a
//   sticky overflow flag when all cells are taken.
//   Opcode 1 is a dump: if any cell is in use, busy rises and, newest entry
//   first, each entry and class yields one result (load, 64 divider steps
//   through three bit-serial restoring dividers, emit). Each result is
//   shown for exactly one cycle with result_valid high; the receiver cannot
//   stall it. The counters of each reported class are cleared as they are
//   loaded into the dividers.
//   Configuration: cfg_we with cfg_index 0 (enable) or 1 (interval, 0 as 1),
//   written only while busy is low and no result is pending.
//   Reset: all cells empty, counters zero, overflow flag clear, counting on,
//   interval 60.
module per_exporter_protocol_counters (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        opcode,
    input  logic [31:0] exporter_id,
    input  logic [7:0]  protocol,
    input  logic [31:0] packet_count,
    input  logic [39:0] byte_count,
    output logic        result_valid,
    output logic [31:0] entry_exporter,
    output logic [1:0]  proto_class,
    output logic [63:0] flow_rate,
    output logic [63:0] packet_rate,
    output logic [63:0] byte_rate,
    output logic        last_of_dump,
    output logic        table_overflowed
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam int N = pepc_pkg::TABLE_ENTRIES;

    logic [1:0]                    state_reg, state_next;
    logic                          en_reg;
    logic [11:0]                   ivl_reg;
    logic                          ovf_reg;
    logic [11:0]                   div_reg;
    logic [pepc_pkg::ENT_W-1:0]    ent_reg;
    logic [1:0]                    cls_reg;
    logic [pepc_pkg::STEP_W-1:0]   step_reg;
    logic [pepc_pkg::ENT_W:0]      used_reg;

    logic                          accept;
    logic                          upd;
    logic                          any_hit;
    logic                          full;
    pepc_pkg::cell_ctrl_t          ctrl;
    logic [N:0]                    vchain;
    logic [N-1:0]                  hits;
    logic [31:0]                   ids  [N];
    pepc_pkg::cnt_set_t            cnts [N];
    pepc_pkg::cnt_kinds_t          sel_cnt;
    logic [63:0]                   q_flow, q_pkt, q_byte;

    logic                          rv_reg;
    logic [31:0]                   exp_reg;
    logic [1:0]                    pc_reg;
    logic [63:0]                   fr_reg, pr_reg, br_reg;
    logic                          last_reg;
    logic                          tov_reg;

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign upd     = accept && (opcode == pepc_pkg::OP_UPDATE) && en_reg;
    assign any_hit = |hits;
    assign full    = vchain[N];

    always_comb
    begin
        ctrl.upd     = upd;
        ctrl.any_hit = any_hit;
        ctrl.clr     = (state_reg == ST_LOAD);
        ctrl.cls     = ctrl.clr ? cls_reg : pepc_pkg::class_of(protocol);
        ctrl.id      = exporter_id;
        ctrl.pkts    = packet_count;
        ctrl.bytes   = byte_count;
    end

    // Row of cells; each one learns from its neighbor whether it is next to fill.
    assign vchain[0] = 1'b1;
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        pepc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .clr_sel    (ent_reg == pepc_pkg::ENT_W'(i)),
            .prev_valid (vchain[i]),
            .valid      (vchain[i+1]),
            .hit        (hits[i]),
            .id         (ids[i]),
            .cnts       (cnts[i])
        );
    end

    assign sel_cnt = cnts[ent_reg][cls_reg];

    pepc_div u_div_flow (
        .clk (clk), .load (ctrl.clr), .step (state_reg == ST_DIV),
        .dividend (sel_cnt[pepc_pkg::KIND_FLOW]), .divisor (div_reg), .quotient (q_flow)
    );
    pepc_div u_div_pkt (
        .clk (clk), .load (ctrl.clr), .step (state_reg == ST_DIV),
        .dividend (sel_cnt[pepc_pkg::KIND_PKT]), .divisor (div_reg), .quotient (q_pkt)
    );
    pepc_div u_div_byte (
        .clk (clk), .load (ctrl.clr), .step (state_reg == ST_DIV),
        .dividend (sel_cnt[pepc_pkg::KIND_BYTE]), .divisor (div_reg), .quotient (q_byte)
    );

    // Dump sequencer: load, divide, emit, then advance class and entry.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && opcode == pepc_pkg::OP_DUMP && used_reg != '0)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:
            begin
                if (step_reg == '1)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (ent_reg == '0 && cls_reg == pepc_pkg::CLS_OTHER)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            en_reg    <= 1'b1;
            ivl_reg   <= 12'd60;
            ovf_reg   <= 1'b0;
            used_reg  <= '0;
            rv_reg    <= 1'b0;
            ent_reg   <= '0;
            cls_reg   <= '0;
            step_reg  <= '0;
            div_reg   <= 12'd1;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= (state_reg == ST_EMIT);
            if (cfg_we)
            begin
                if (cfg_index == pepc_pkg::REG_ENABLE)
                begin
                    en_reg <= cfg_data[0];
                end
                else
                begin
                    ivl_reg <= cfg_data;
                end
            end
            // Count a claimed cell, or flag the drop when the row is full.
            if (upd && !any_hit)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    used_reg <= used_reg + 1'b1;
                end
            end
            if (state_reg == ST_IDLE && state_next == ST_LOAD)
            begin
                ent_reg <= pepc_pkg::ENT_W'(used_reg - 1'b1);
                cls_reg <= pepc_pkg::CLS_TCP;
                div_reg <= (ivl_reg == '0) ? 12'd1 : ivl_reg;
            end
            if (state_reg == ST_LOAD)
            begin
                step_reg <= '0;
            end
            else if (state_reg == ST_DIV)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (state_reg == ST_EMIT)
            begin
                if (cls_reg == pepc_pkg::CLS_OTHER)
                begin
                    cls_reg <= pepc_pkg::CLS_TCP;
                    ent_reg <= ent_reg - 1'b1;
                end
                else
                begin
                    cls_reg <= cls_reg + 1'b1;
                end
            end
        end
    end

    // Hold the result registers for the single strobe cycle.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT)
        begin
            exp_reg  <= ids[ent_reg];
            pc_reg   <= cls_reg;
            fr_reg   <= q_flow;
            pr_reg   <= q_pkt;
            br_reg   <= q_byte;
            last_reg <= (ent_reg == '0) && (cls_reg == pepc_pkg::CLS_OTHER);
            tov_reg  <= ovf_reg;
        end
    end

    assign result_valid     = rv_reg;
    assign entry_exporter   = exp_reg;
    assign proto_class      = pc_reg;
    assign flow_rate        = fr_reg;
    assign packet_rate      = pr_reg;
    assign byte_rate        = br_reg;
    assign last_of_dump     = last_reg;
    assign table_overflowed = tov_reg;
endmodule

// ===== dv/tb_per_exporter_protocol_counters.sv =====
// Self-checking testbench for the per-exporter protocol counters.
`timescale 1ns / 1ps
module tb_per_exporter_protocol_counters;

    // Clock, reset and the block's ports
    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cfg_we;
    logic        cfg_index;
    logic [11:0] cfg_data;
    logic        opcode;
    logic [31:0] exporter_id;
    logic [7:0]  protocol;
    logic [31:0] packet_count;
    logic [39:0] byte_count;
    logic        result_valid;
    logic [31:0] entry_exporter;
    logic [1:0]  proto_class;
    logic [63:0] flow_rate;
    logic [63:0] packet_rate;
    logic [63:0] byte_rate;
    logic        last_of_dump;
    logic        table_overflowed;

    per_exporter_protocol_counters uut (.*);

    // One command as the driver sees it
    typedef struct {
        logic        op;
        logic [31:0] id;
        logic [7:0]  proto;
        logic [31:0] pkts;
        logic [39:0] bytes;
    } command_t;

    // One rate report as the monitor expects it
    typedef struct {
        logic [31:0] exporter;
        logic [1:0]  cls;
        logic [63:0] flows;
        logic [63:0] packets;
        logic [63:0] bytes;
        logic        last;
        logic        ovf;
    } rate_report_t;

    command_t     pending_cmds[$];
    rate_report_t expected_reports[$];

    // Shadow copy of the block's state
    logic [31:0] shadow_ids[pepc_pkg::TABLE_ENTRIES];
    int          shadow_used;
    logic [63:0] shadow_cnt[pepc_pkg::TABLE_ENTRIES][pepc_pkg::NUM_CLASSES][pepc_pkg::NUM_KINDS];
    logic        shadow_ovf;
    logic        shadow_enable;
    logic [11:0] shadow_interval;

    int  errors;
    int  sent_cmds;
    int  checked_reports;
    int  dumps_sent;
    int  idle_pct;
    int  stall_cycles;
    logic finishing;

    localparam int WATCHDOG_LIMIT = 40000;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Map a protocol number to its counting class
    function automatic logic [1:0] protocol_class(input logic [7:0] p);
        if (p == pepc_pkg::PROTO_TCP) return pepc_pkg::CLS_TCP;
        if (p == pepc_pkg::PROTO_UDP) return pepc_pkg::CLS_UDP;
        if (p == pepc_pkg::PROTO_ICMP || p == pepc_pkg::PROTO_ICMPV6) return pepc_pkg::CLS_ICMP;
        return pepc_pkg::CLS_OTHER;
    endfunction

    // Apply one accepted command to the shadow state; push any rate reports
    task automatic account_command(input command_t c);
        int slot;
        logic [1:0] k;
        logic [63:0] div;
        rate_report_t r;
        slot = -1;
        if (c.op == pepc_pkg::OP_UPDATE) begin
            if (!shadow_enable) return;
            for (int e = 0; e < shadow_used; e++)
                if (slot < 0 && shadow_ids[e] == c.id) slot = e;
            if (slot < 0) begin
                if (shadow_used >= pepc_pkg::TABLE_ENTRIES) begin
                    shadow_ovf = 1'b1;
                    return;
                end
                slot = shadow_used;
                shadow_ids[slot] = c.id;
                shadow_used++;
            end
            k = protocol_class(c.proto);
            shadow_cnt[slot][k][pepc_pkg::KIND_FLOW] += 64'd1;
            shadow_cnt[slot][k][pepc_pkg::KIND_PKT]  += {32'd0, c.pkts};
            shadow_cnt[slot][k][pepc_pkg::KIND_BYTE] += {24'd0, c.bytes};
        end else begin
            div = (shadow_interval == 12'd0) ? 64'd1 : {52'd0, shadow_interval};
            for (int e = shadow_used - 1; e >= 0; e--)
                for (int cl = 0; cl < pepc_pkg::NUM_CLASSES; cl++) begin
                    r.exporter = shadow_ids[e];
                    r.cls      = cl[1:0];
                    r.flows    = shadow_cnt[e][cl][pepc_pkg::KIND_FLOW] / div;
                    r.packets  = shadow_cnt[e][cl][pepc_pkg::KIND_PKT] / div;
                    r.bytes    = shadow_cnt[e][cl][pepc_pkg::KIND_BYTE] / div;
                    r.last     = (e == 0 && cl == pepc_pkg::NUM_CLASSES - 1);
                    r.ovf      = shadow_ovf;
                    expected_reports.push_back(r);
                    for (int kd = 0; kd < pepc_pkg::NUM_KINDS; kd++)
                        shadow_cnt[e][cl][kd] = '0;
                end
        end
    endtask

    // Driver: hold each command until the block takes it
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start        <= 1'b0;
            opcode       <= pepc_pkg::OP_UPDATE;
            exporter_id  <= '0;
            protocol     <= '0;
            packet_count <= '0;
            byte_count   <= '0;
        end else begin
            logic taken;
            taken = start && !busy;
            if (taken) begin
                account_command(pending_cmds.pop_front());
                sent_cmds++;
            end
            if ((!start || taken) && pending_cmds.size() > 0
                && $urandom_range(99) >= idle_pct) begin
                start        <= 1'b1;
                opcode       <= pending_cmds[0].op;
                exporter_id  <= pending_cmds[0].id;
                protocol     <= pending_cmds[0].proto;
                packet_count <= pending_cmds[0].pkts;
                byte_count   <= pending_cmds[0].bytes;
            end else if (taken) begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: results cannot be stalled, so check every strobe
    always @(posedge clk)
    begin
        if (rst_n && result_valid) begin
            rate_report_t x;
            if (expected_reports.size() == 0) begin
                $error("unexpected result for exporter %h", entry_exporter);
                errors++;
            end else begin
                x = expected_reports.pop_front();
                checked_reports++;
                if (entry_exporter !== x.exporter) begin
                    $error("entry_exporter exp %h got %h", x.exporter, entry_exporter);
                    errors++;
                end
                if (proto_class !== x.cls) begin
                    $error("proto_class exp %0d got %0d", x.cls, proto_class);
                    errors++;
                end
                if (flow_rate !== x.flows) begin
                    $error("flow_rate exp %0d got %0d", x.flows, flow_rate);
                    errors++;
                end
                if (packet_rate !== x.packets) begin
                    $error("packet_rate exp %0d got %0d", x.packets, packet_rate);
                    errors++;
                end
                if (byte_rate !== x.bytes) begin
                    $error("byte_rate exp %0d got %0d", x.bytes, byte_rate);
                    errors++;
                end
                if (last_of_dump !== x.last) begin
                    $error("last_of_dump exp %0b got %0b", x.last, last_of_dump);
                    errors++;
                end
                if (table_overflowed !== x.ovf) begin
                    $error("table_overflowed exp %0b got %0b", x.ovf, table_overflowed);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles in which neither a command nor a result moves
    always @(posedge clk)
    begin
        if (!rst_n || finishing || (start && !busy) || result_valid
            || (pending_cmds.size() == 0 && expected_reports.size() == 0 && !busy)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Queue one command
    task automatic add_cmd(input logic op, input logic [31:0] id, input logic [7:0] p,
                           input logic [31:0] pk, input logic [39:0] by);
        command_t c;
        c.op = op; c.id = id; c.proto = p; c.pkts = pk; c.bytes = by;
        pending_cmds.push_back(c);
        if (op == pepc_pkg::OP_DUMP) dumps_sent++;
    endtask

    // Wait until every queued command and every report has gone through
    task automatic drain();
        while (pending_cmds.size() > 0 || expected_reports.size() > 0 || busy || start)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // Write a register while the block is idle
    task automatic write_reg(input logic idx, input logic [11:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == pepc_pkg::REG_ENABLE) shadow_enable = val[0];
        else shadow_interval = val;
    endtask

    // Pick a protocol, leaning on the four special numbers
    function automatic logic [7:0] rand_proto();
        case ($urandom_range(5))
            0: return pepc_pkg::PROTO_TCP;
            1: return pepc_pkg::PROTO_UDP;
            2: return pepc_pkg::PROTO_ICMP;
            3: return pepc_pkg::PROTO_ICMPV6;
            default: return 8'($urandom);
        endcase
    endfunction

    // A burst of updates from a small pool of exporters, then a dump
    task automatic random_burst(input int n_upd, input int pool, input logic [31:0] base);
        logic [39:0] by;
        for (int i = 0; i < n_upd; i++) begin
            by = {8'($urandom), 32'($urandom)};
            if ($urandom_range(3) == 0) by = by & 40'hFF_FFFF;
            add_cmd(pepc_pkg::OP_UPDATE, ($urandom_range(9) == 0) ? $urandom
                               : base + $urandom_range(pool - 1),
                    rand_proto(), ($urandom_range(3) == 0) ? 32'($urandom_range(100))
                                                           : $urandom, by);
        end
        add_cmd(pepc_pkg::OP_DUMP, $urandom, 8'($urandom), $urandom, '0);
    endtask

    initial
    begin
        errors = 0; sent_cmds = 0; checked_reports = 0; dumps_sent = 0;
        idle_pct = 0; stall_cycles = 0; finishing = 1'b0;
        shadow_used = 0; shadow_ovf = 1'b0; shadow_enable = 1'b1;
        shadow_interval = 12'd60;
        foreach (shadow_cnt[e, c, k]) shadow_cnt[e][c][k] = '0;
        foreach (shadow_ids[e]) shadow_ids[e] = '0;
        cfg_we = 1'b0; cfg_index = pepc_pkg::REG_ENABLE; cfg_data = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: dump of an empty table, every class, extremes, default interval
        add_cmd(pepc_pkg::OP_DUMP, '0, '0, '0, '0);
        add_cmd(pepc_pkg::OP_UPDATE, 32'hFFFF_FFFF, pepc_pkg::PROTO_TCP, 32'hFFFF_FFFF,
                40'hFF_FFFF_FFFF);
        add_cmd(pepc_pkg::OP_UPDATE, 32'hFFFF_FFFF, pepc_pkg::PROTO_UDP, 32'd0, 40'd0);
        add_cmd(pepc_pkg::OP_UPDATE, 32'h0, pepc_pkg::PROTO_ICMP, 32'd600, 40'd6000);
        add_cmd(pepc_pkg::OP_UPDATE, 32'h0, pepc_pkg::PROTO_ICMPV6, 32'd59, 40'd120);
        add_cmd(pepc_pkg::OP_UPDATE, 32'h0, 8'hFF, 32'd1, 40'd1);
        add_cmd(pepc_pkg::OP_UPDATE, 32'hFFFF_FFFF, pepc_pkg::PROTO_TCP, 32'hFFFF_FFFF,
                40'hFF_FFFF_FFFF);
        add_cmd(pepc_pkg::OP_DUMP, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
        drain();

        // Interval 1 and a zero interval, both leave the counts undivided
        write_reg(pepc_pkg::REG_INTERVAL, 12'd1);
        add_cmd(pepc_pkg::OP_UPDATE, 32'h5555_AAAA, 8'd0, 32'd7, 40'd9);
        add_cmd(pepc_pkg::OP_DUMP, '0, '0, '0, '0);
        drain();
        write_reg(pepc_pkg::REG_INTERVAL, 12'd0);
        add_cmd(pepc_pkg::OP_UPDATE, 32'hAAAA_5555, pepc_pkg::PROTO_UDP, 32'd3, 40'd4);
        add_cmd(pepc_pkg::OP_DUMP, '0, '0, '0, '0);
        drain();

        // Counting disabled: updates ignored, dump still runs
        write_reg(pepc_pkg::REG_ENABLE, 1'b0);
        add_cmd(pepc_pkg::OP_UPDATE, 32'h1234_5678, pepc_pkg::PROTO_TCP, 32'd100, 40'd100);
        add_cmd(pepc_pkg::OP_DUMP, '0, '0, '0, '0);
        drain();
        write_reg(pepc_pkg::REG_ENABLE, 1'b1);
        write_reg(pepc_pkg::REG_INTERVAL, 12'd3600);

        // Random phases; the table fills up along the way and overflows
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 61 : (ph == 3) ? 19 : 0;
            write_reg(pepc_pkg::REG_INTERVAL,
                      (ph == 2) ? 12'd4095 : 12'($urandom_range(1, 3600)));
            for (int b = 0; b < 5; b++)
                random_burst($urandom_range(10, 30), 4, 32'h1000 * (ph * 5 + b));
            if (ph == 2) begin
                drain();
                write_reg(pepc_pkg::REG_ENABLE, 1'b0);
                random_burst(6, 3, 32'h10);
                drain();
                write_reg(pepc_pkg::REG_ENABLE, 1'b1);
            end
            drain();
        end

        finishing = 1'b1;
        $display("Ran %0d commands with %0d dumps; checked %0d rate reports.",
                 sent_cmds, dumps_sent, checked_reports);
        $display("Covered every class, extreme fields, disabled counting, zero and max intervals.");
        if (errors == 0 && expected_reports.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
